// ===== rtl/tlpt_pkg.sv =====
// Shared constants, codes and the queued command type of the page table engine.
// Used by the front, queue, back and top RTL files; depends on nothing.
package tlpt_pkg;

    // Number of page tables in the pool.
    localparam int TABLE_SLOTS = 16;

    // Field widths of the address split and of the stores.
    localparam int IDX_W       = 10;
    localparam int OFF_W       = 12;
    localparam int FRAME_W     = 20;
    localparam int SLOT_W      = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int DIR_W       = SLOT_W + 3;
    localparam int TAB_AW      = SLOT_W + IDX_W;
    localparam int CNT_W       = $clog2(TABLE_SLOTS + 1);
    localparam int DIR_ENTRIES = 1 << IDX_W;
    localparam int TAB_ENTRIES = TABLE_SLOTS * DIR_ENTRIES;

    // Command queue between the front and back parts.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Request actions as they arrive.
    localparam logic [1:0] ACT_MAP   = 2'd0;
    localparam logic [1:0] ACT_UNMAP = 2'd1;
    localparam logic [1:0] ACT_XLATE = 2'd2;
    localparam logic [1:0] ACT_FAULT = 2'd3;

    // Operations after classification.
    localparam logic [1:0] OP_MAP   = 2'd0;
    localparam logic [1:0] OP_UNMAP = 2'd1;
    localparam logic [1:0] OP_XLATE = 2'd2;
    localparam logic [1:0] OP_HALT  = 2'd3;

    // Result status codes.
    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_ABSENT  = 2'd1;
    localparam logic [1:0] ST_NO_SLOT = 2'd2;
    localparam logic [1:0] ST_HALTED  = 2'd3;

    // Fault code bits.
    localparam int ERR_PROTECTION = 0;
    localparam int ERR_USER       = 2;
    localparam int ERR_RESERVED   = 3;

    // Entry flag bits.
    localparam int BIT_PRESENT = 0;
    localparam int BIT_USER    = 2;

    typedef struct packed {
        logic [1:0]       op;
        logic [IDX_W-1:0] dir_idx;
        logic [IDX_W-1:0] tab_idx;
        logic [OFF_W-1:0] offset;
        logic [31:0]      leaf;
        logic             user;
    } cmd_t;

endpackage

// ===== rtl/tlpt_if.sv =====
// Request and response channel interfaces of the page table engine.
// Standalone; carries valid, ready and the payload fields.
interface tlpt_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [31:0] virtual_address;
    logic [31:0] physical_address;
    logic [11:0] map_flags;
    logic [3:0]  fault_code;
    logic [19:0] fault_frame;

    modport source (
        output valid, action, virtual_address, physical_address, map_flags,
               fault_code, fault_frame,
        input  ready
    );
    modport sink (
        input  valid, action, virtual_address, physical_address, map_flags,
               fault_code, fault_frame,
        output ready
    );
endinterface

interface tlpt_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [31:0] translated_address;

    modport source (
        output valid, status, translated_address,
        input  ready
    );
    modport sink (
        input  valid, status, translated_address,
        output ready
    );
endinterface

// ===== rtl/tlpt_front.sv =====
// Front part: accepts requests, classifies them into queued commands.
// Depends on tlpt_pkg and the request interface.
module tlpt_front
    import tlpt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    tlpt_req_if.sink    req,
    output logic        cmd_valid,
    input  logic        cmd_ready,
    output cmd_t        cmd
);

    logic valid_reg;
    logic valid_next;
    cmd_t cmd_reg;
    cmd_t cmd_next;
    logic accept;
    logic fault_bad;

    assign req.ready = !valid_reg || cmd_ready;
    assign accept    = req.valid && req.ready;
    assign cmd_valid = valid_reg;
    assign cmd       = cmd_reg;

    assign fault_bad = req.fault_code[ERR_PROTECTION] || req.fault_code[ERR_RESERVED]
                    || (req.fault_frame == '0);

    always_comb
    begin
        cmd_next.dir_idx = req.virtual_address[31:22];
        cmd_next.tab_idx = req.virtual_address[21:12];
        cmd_next.offset  = req.virtual_address[11:0];
        cmd_next.leaf    = {req.physical_address[31:12], req.map_flags[11:1], 1'b1};
        cmd_next.user    = req.map_flags[BIT_USER];
        unique case (req.action)
            ACT_MAP:   cmd_next.op = OP_MAP;
            ACT_UNMAP: cmd_next.op = OP_UNMAP;
            ACT_XLATE: cmd_next.op = OP_XLATE;
            ACT_FAULT:
            begin
                // A clean fault maps the page present and writable to the given frame.
                cmd_next.op   = fault_bad ? OP_HALT : OP_MAP;
                cmd_next.leaf = {req.fault_frame, 9'd0, req.fault_code[ERR_USER], 2'b11};
                cmd_next.user = req.fault_code[ERR_USER];
            end
            default:   cmd_next.op = OP_HALT;
        endcase
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (cmd_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= cmd_next;
        end
    end

endmodule

// ===== rtl/tlpt_queue.sv =====
// Short command queue between the front and back parts.
// Depends on tlpt_pkg for the command type and depth.
module tlpt_queue
    import tlpt_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  cmd_t in_cmd,
    output logic out_valid,
    input  logic out_ready,
    output cmd_t out_cmd
);

    cmd_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              push;
    logic              pop;

    assign in_ready  = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_cmd   = entry_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

// ===== rtl/tlpt_back.sv =====
// Back part: sequencer over the directory and table memories, plus result register.
// Depends on tlpt_pkg and the response interface.
module tlpt_back
    import tlpt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cmd_valid,
    output logic        cmd_ready,
    input  cmd_t        cmd,
    tlpt_rsp_if.source  rsp
);

    localparam logic [2:0] S_INIT  = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_DIR   = 3'd2;
    localparam logic [2:0] S_CLEAR = 3'd3;
    localparam logic [2:0] S_LEAF  = 3'd4;
    localparam logic [2:0] S_HOLD  = 3'd5;

    // Memories.
    logic [DIR_W-1:0]  dir_mem [DIR_ENTRIES];
    logic [31:0]       tab_mem [TAB_ENTRIES];
    logic [DIR_W-1:0]  dir_rd_reg;
    logic [31:0]       tab_rd_reg;
    logic              dir_we;
    logic [IDX_W-1:0]  dir_wa;
    logic [DIR_W-1:0]  dir_wd;
    logic [IDX_W-1:0]  dir_ra;
    logic              tab_we;
    logic [TAB_AW-1:0] tab_wa;
    logic [31:0]       tab_wd;
    logic [TAB_AW-1:0] tab_ra;

    // Control and state.
    logic [2:0]        state_reg;
    logic [2:0]        state_next;
    logic [IDX_W-1:0]  cnt_reg;
    logic [IDX_W-1:0]  cnt_next;
    logic [CNT_W-1:0]  free_reg;
    logic [CNT_W-1:0]  free_next;
    logic              halted_reg;
    logic              halted_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    cmd_t              cmd_reg;
    cmd_t              cmd_next;
    logic [SLOT_W-1:0] clr_slot_reg;
    logic [SLOT_W-1:0] clr_slot_next;
    logic [1:0]        pend_status_reg;
    logic [1:0]        pend_status_next;
    logic [31:0]       pend_addr_reg;
    logic [31:0]       pend_addr_next;
    logic [1:0]        out_status_reg;
    logic [1:0]        out_status_next;
    logic [31:0]       out_addr_reg;
    logic [31:0]       out_addr_next;

    logic              res_fire;
    logic [1:0]        res_status;
    logic [31:0]       res_addr;
    logic              out_free;
    logic              dent_present;
    logic [SLOT_W-1:0] dent_slot;

    assign out_free               = !out_valid_reg || rsp.ready;
    assign rsp.valid              = out_valid_reg;
    assign rsp.status             = out_status_reg;
    assign rsp.translated_address = out_addr_reg;
    assign cmd_ready              = (state_reg == S_IDLE);
    assign dent_present           = dir_rd_reg[BIT_PRESENT];
    assign dent_slot              = dir_rd_reg[DIR_W-1:3];

    always_comb
    begin
        state_next       = state_reg;
        cnt_next         = cnt_reg;
        free_next        = free_reg;
        halted_next      = halted_reg;
        cmd_next         = cmd_reg;
        clr_slot_next    = clr_slot_reg;
        pend_status_next = pend_status_reg;
        pend_addr_next   = pend_addr_reg;
        out_status_next  = out_status_reg;
        out_addr_next    = out_addr_reg;
        out_valid_next   = out_valid_reg && !rsp.ready;

        dir_we = 1'b0;
        dir_wa = cmd_reg.dir_idx;
        dir_wd = '0;
        dir_ra = cmd.dir_idx;
        tab_we = 1'b0;
        tab_wa = {dent_slot, cmd_reg.tab_idx};
        tab_wd = '0;
        tab_ra = {dent_slot, cmd_reg.tab_idx};

        res_fire   = 1'b0;
        res_status = ST_DONE;
        res_addr   = '0;

        unique case (state_reg)
            S_INIT:
            begin
                // Clearing pass over the directory after reset.
                dir_we   = 1'b1;
                dir_wa   = cnt_reg;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == '1)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_next = cmd;
                    if (halted_reg)
                    begin
                        res_fire   = 1'b1;
                        res_status = ST_HALTED;
                    end
                    else if (cmd.op == OP_HALT)
                    begin
                        halted_next = 1'b1;
                        res_fire    = 1'b1;
                        res_status  = ST_HALTED;
                    end
                    else
                    begin
                        state_next = S_DIR;
                    end
                end
            end
            S_DIR:
            begin
                unique case (cmd_reg.op)
                    OP_MAP:
                    begin
                        if (dent_present)
                        begin
                            tab_we   = 1'b1;
                            tab_wd   = cmd_reg.leaf;
                            res_fire = 1'b1;
                        end
                        else if (free_reg == CNT_W'(TABLE_SLOTS))
                        begin
                            res_fire   = 1'b1;
                            res_status = ST_NO_SLOT;
                        end
                        else
                        begin
                            // Take a fresh table and point the directory at it.
                            clr_slot_next = free_reg[SLOT_W-1:0];
                            free_next     = free_reg + 1'b1;
                            dir_we        = 1'b1;
                            dir_wd        = {free_reg[SLOT_W-1:0], cmd_reg.user, 2'b11};
                            cnt_next      = '0;
                            state_next    = S_CLEAR;
                        end
                    end
                    OP_UNMAP:
                    begin
                        res_fire = 1'b1;
                        if (dent_present)
                        begin
                            tab_we = 1'b1;
                        end
                        else
                        begin
                            res_status = ST_ABSENT;
                        end
                    end
                    OP_XLATE:
                    begin
                        if (dent_present)
                        begin
                            state_next = S_LEAF;
                        end
                        else
                        begin
                            res_fire   = 1'b1;
                            res_status = ST_ABSENT;
                        end
                    end
                    default:
                    begin
                        res_fire = 1'b1;
                    end
                endcase
            end
            S_CLEAR:
            begin
                // Zero the new table; the requested leaf is written when the pass
                // reaches its index.
                tab_we   = 1'b1;
                tab_wa   = {clr_slot_reg, cnt_reg};
                tab_wd   = (cnt_reg == cmd_reg.tab_idx) ? cmd_reg.leaf : '0;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == '1)
                begin
                    res_fire = 1'b1;
                end
            end
            S_LEAF:
            begin
                res_fire = 1'b1;
                if (tab_rd_reg[BIT_PRESENT])
                begin
                    res_addr = {tab_rd_reg[31:12], cmd_reg.offset};
                end
                else
                begin
                    res_status = ST_ABSENT;
                end
            end
            S_HOLD:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = pend_status_reg;
                    out_addr_next   = pend_addr_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (res_fire)
        begin
            if (out_free)
            begin
                out_valid_next  = 1'b1;
                out_status_next = res_status;
                out_addr_next   = res_addr;
                state_next      = S_IDLE;
            end
            else
            begin
                pend_status_next = res_status;
                pend_addr_next   = res_addr;
                state_next       = S_HOLD;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            cnt_reg       <= '0;
            free_reg      <= '0;
            halted_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            free_reg      <= free_next;
            halted_reg    <= halted_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg         <= cmd_next;
        clr_slot_reg    <= clr_slot_next;
        pend_status_reg <= pend_status_next;
        pend_addr_reg   <= pend_addr_next;
        out_status_reg  <= out_status_next;
        out_addr_reg    <= out_addr_next;
    end

    always_ff @(posedge clk)
    begin
        if (dir_we)
        begin
            dir_mem[dir_wa] <= dir_wd;
        end
        dir_rd_reg <= dir_mem[dir_ra];
    end

    always_ff @(posedge clk)
    begin
        if (tab_we)
        begin
            tab_mem[tab_wa] <= tab_wd;
        end
        tab_rd_reg <= tab_mem[tab_ra];
    end

endmodule

// ===== rtl/two_level_page_table_engine_unit.sv =====
// Top level of the two-level page table engine: front, command queue and back.
// Depends on tlpt_pkg, the channel interfaces and the three submodules.
//
//   channel | modport | payload                                         | role
//   --------+---------+-------------------------------------------------+-----------------
//   req     | sink    | action, virtual_address, physical_address,      | incoming request
//           |         | map_flags, fault_code, fault_frame              |
//   rsp     | source  | status, translated_address                      | one result each
//
// After reset the directory memory is cleared one entry a cycle; requests are
// queued during that pass but no result comes out until it ends. Past the
// front register, the back sequencer answers a halted or failed-fault request
// from idle, a map into an existing table, an unmap or a translate miss from
// the directory read, a translate that reads the table from the leaf read, and
// a map that takes a new table once the one-entry-a-cycle table clear is done.
// A stalled response holds in the output register while the front and the
// two-entry queue keep taking requests.
module two_level_page_table_engine_unit
    import tlpt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    tlpt_req_if.sink    req,
    tlpt_rsp_if.source  rsp
);

    // Front register to queue.
    logic f_valid;
    logic f_ready;
    cmd_t f_cmd;

    // Queue to back sequencer.
    logic q_valid;
    logic q_ready;
    cmd_t q_cmd;

    // The front turns each request into a command, with fault checks resolved.
    tlpt_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd_valid (f_valid),
        .cmd_ready (f_ready),
        .cmd       (f_cmd)
    );

    // The queue lets the front keep accepting while the back is busy.
    tlpt_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_cmd    (f_cmd),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_cmd   (q_cmd)
    );

    // The back owns the directory, the table pool, the halt flag and the result.
    tlpt_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (q_valid),
        .cmd_ready (q_ready),
        .cmd       (q_cmd),
        .rsp       (rsp)
    );

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the two-level page table engine unit.
// Depends on tlpt_pkg, the channel interfaces and the engine top from the RTL; reads no files.
// Directed tables around three phases of random requests, checked against a local model.
module testbench;
    import tlpt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // The leaf and directory write bit; the package names only present and user.
    localparam int WRITE_BIT = 1;

    // Cycles without any handshake before the run is declared hung. The slowest
    // legitimate gap is the directory clear after reset or a table clear, plus a
    // short output stall, and this limit sits well above it.
    localparam int WATCHDOG_LIMIT = 12000;

    // Quiet time at the end, long enough for a stray response behind a table clear.
    localparam int TAIL_CYCLES = 1100;

    localparam int RANDOM_PER_PHASE = 542;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] addr;
    } page_result_t;

    typedef struct {
        logic [1:0]   action;
        logic [31:0]  va;
        logic [31:0]  pa;
        logic [11:0]  flags;
        logic [3:0]   code;
        logic [19:0]  frame;
        bit           typed;
        page_result_t want;
    } page_request_t;

    logic clk = 1'b0;
    logic rst_n;

    tlpt_req_if req_ch ();
    tlpt_rsp_if rsp_ch ();

    two_level_page_table_engine_unit i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Local copy of the engine state. Directory entries hold present in bit 0,
    // write in bit 1, user in bit 2 and the pool slot above that.
    logic [DIR_W-1:0] dir_model [DIR_ENTRIES];
    logic [31:0]      leaf_model [TAB_ENTRIES];
    int unsigned      tables_taken;
    bit               engine_halted;

    // Responses still owed by the engine, oldest first.
    page_result_t  pending_results [$];

    page_request_t opening_rows [$];
    page_request_t closing_rows [$];

    // Random addresses favor a small set of directory slots and recently mapped
    // pages so that translates and unmaps mostly land on live entries.
    int unsigned dir_choices [24];
    logic [31:0] recent_pages [$];

    int tx_idle_pct;
    int rx_idle_pct;
    int error_count;
    int quiet_cycles;
    int action_count [4];
    int status_count [4];

    function automatic int unsigned leaf_index(input logic [DIR_W-1:0] dent,
                                               input logic [31:0] va);
        return 32'({dent[DIR_W-1:3], va[21:12]});
    endfunction

    // Writes one leaf entry, first taking and clearing a fresh table from the
    // pool when the directory entry is absent.
    function automatic logic [1:0] model_map(input logic [31:0] va, input logic [31:0] pa,
                                             input logic [11:0] flags);
        logic [IDX_W-1:0]  di;
        logic [DIR_W-1:0]  dent;
        logic [SLOT_W-1:0] slot;
        di = va[31:22];
        dent = dir_model[di];
        if (!dent[BIT_PRESENT])
        begin
            if (tables_taken >= TABLE_SLOTS)
                return ST_NO_SLOT;
            slot = SLOT_W'(tables_taken);
            for (int i = 0; i < DIR_ENTRIES; i++)
                leaf_model[tables_taken * DIR_ENTRIES + i] = '0;
            dent = '0;
            dent[DIR_W-1:3] = slot;
            dent[BIT_PRESENT] = 1'b1;
            dent[WRITE_BIT] = 1'b1;
            dent[BIT_USER] = flags[BIT_USER];
            dir_model[di] = dent;
            tables_taken++;
        end
        leaf_model[leaf_index(dent, va)] = {pa[31:12], flags | 12'h001};
        return ST_DONE;
    endfunction

    // Applies one request to the local state and returns the response it owes.
    function automatic page_result_t model_request(input page_request_t r);
        page_result_t      res;
        logic [DIR_W-1:0]  dent;
        logic [31:0]       pte;
        logic [11:0]       fault_flags;
        res = '0;
        dent = dir_model[r.va[31:22]];
        if (engine_halted)
            res.status = ST_HALTED;
        else
        begin
            case (r.action)
                ACT_MAP:
                    res.status = model_map(r.va, r.pa, r.flags);
                ACT_UNMAP:
                    if (dent[BIT_PRESENT])
                        leaf_model[leaf_index(dent, r.va)] = '0;
                    else
                        res.status = ST_ABSENT;
                ACT_XLATE:
                begin
                    pte = leaf_model[leaf_index(dent, r.va)];
                    if (!dent[BIT_PRESENT] || !pte[BIT_PRESENT])
                        res.status = ST_ABSENT;
                    else
                        res.addr = {pte[31:12], r.va[11:0]};
                end
                default:
                begin
                    // A fault with an error bit or no frame to hand out halts for good.
                    if (r.code[ERR_PROTECTION] || r.code[ERR_RESERVED] || r.frame == '0)
                    begin
                        engine_halted = 1'b1;
                        res.status = ST_HALTED;
                    end
                    else
                    begin
                        fault_flags = '0;
                        fault_flags[BIT_PRESENT] = 1'b1;
                        fault_flags[WRITE_BIT] = 1'b1;
                        fault_flags[BIT_USER] = r.code[ERR_USER];
                        res.status = model_map({r.va[31:12], 12'h000}, {r.frame, 12'h000},
                                               fault_flags);
                    end
                end
            endcase
        end
        return res;
    endfunction

    function automatic page_request_t make_row(
        input logic [1:0] action, input logic [31:0] va, input logic [31:0] pa,
        input logic [11:0] flags, input logic [3:0] code, input logic [19:0] frame,
        input bit typed, input logic [1:0] status, input logic [31:0] addr);
        page_request_t r;
        r.action = action;
        r.va = va;
        r.pa = pa;
        r.flags = flags;
        r.code = code;
        r.frame = frame;
        r.typed = typed;
        r.want.status = status;
        r.want.addr = addr;
        return r;
    endfunction

    function automatic page_request_t random_request();
        page_request_t r;
        int            pick;
        logic [9:0]    dir;
        logic [9:0]    tab;
        logic [31:0]   page;
        logic [31:0]   noise;
        pick = $urandom_range(0, 99);
        r.action = (pick < 35) ? ACT_MAP : (pick < 50) ? ACT_UNMAP :
                   (pick < 85) ? ACT_XLATE : ACT_FAULT;
        r.pa = $urandom();
        r.flags = 12'($urandom_range(0, 4095));
        r.code = 4'($urandom_range(0, 15));
        r.frame = 20'($urandom_range(0, 20'hFFFFF));
        if (r.action == ACT_FAULT)
        begin
            // Error faults halt the engine until reset, so they wait for the end.
            r.code[ERR_PROTECTION] = 1'b0;
            r.code[ERR_RESERVED] = 1'b0;
            r.frame = 20'($urandom_range(1, 20'hFFFFF));
        end
        if (recent_pages.size() != 0 && $urandom_range(0, 99) < 60)
            page = recent_pages[$urandom_range(0, recent_pages.size() - 1)];
        else
        begin
            dir = ($urandom_range(0, 4) == 0) ? 10'($urandom_range(0, 1023))
                                              : 10'(dir_choices[$urandom_range(0, 23)]);
            tab = ($urandom_range(0, 3) == 0) ? 10'($urandom_range(0, 1023))
                                              : 10'($urandom_range(0, 15));
            page = {dir, tab, 12'h000};
        end
        noise = $urandom();
        r.va = {page[31:12], noise[11:0]};
        if (r.action == ACT_MAP || r.action == ACT_FAULT)
        begin
            recent_pages.push_back(page);
            if (recent_pages.size() > 32)
                void'(recent_pages.pop_front());
        end
        r.typed = 1'b0;
        r.want = '0;
        return r;
    endfunction

    // Offers one request, idling beforehand at the current sender rate, and
    // records the response it owes once the engine takes it.
    task automatic send_request(input page_request_t r);
        page_result_t res;
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid            <= 1'b1;
        req_ch.action           <= r.action;
        req_ch.virtual_address  <= r.va;
        req_ch.physical_address <= r.pa;
        req_ch.map_flags        <= r.flags;
        req_ch.fault_code       <= r.code;
        req_ch.fault_frame      <= r.frame;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        res = model_request(r);
        pending_results.push_back(r.typed ? r.want : res);
        action_count[r.action]++;
    endtask

    // Holds the request side idle until every owed response has been seen.
    task automatic wait_for_drain();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // The response side stalls at the current receiver rate.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_ch.ready <= 1'b0;
        else
            rsp_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    // Every response is matched against the oldest owed one, field by field.
    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            status_count[rsp_ch.status]++;
            if (pending_results.size() == 0)
            begin
                error_count++;
                $display("%0t: response with none owed, status %0d address %08h",
                         $time, rsp_ch.status, rsp_ch.translated_address);
            end
            else
            begin
                if (rsp_ch.status !== pending_results[0].status)
                begin
                    error_count++;
                    $display("%0t: status mismatch, expected %0d, actual %0d",
                             $time, pending_results[0].status, rsp_ch.status);
                end
                if (rsp_ch.translated_address !== pending_results[0].addr)
                begin
                    error_count++;
                    $display("%0t: translated_address mismatch, expected %08h, actual %08h",
                             $time, pending_results[0].addr, rsp_ch.translated_address);
                end
                void'(pending_results.pop_front());
            end
        end
    end

    // A hung engine shows up as a long stretch with no handshake on either side.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no handshake for %0d cycles, %0d responses still owed",
                         $time, quiet_cycles, pending_results.size());
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    initial
    begin
        int tx_phase [3];
        int rx_phase [3];
        tx_phase = '{17, 86, 0};
        rx_phase = '{86, 17, 0};

        rst_n                   <= 1'b0;
        req_ch.valid            <= 1'b0;
        req_ch.action           <= ACT_MAP;
        req_ch.virtual_address  <= '0;
        req_ch.physical_address <= '0;
        req_ch.map_flags        <= '0;
        req_ch.fault_code       <= '0;
        req_ch.fault_frame      <= '0;
        error_count = 0;
        quiet_cycles = 0;
        tables_taken = 0;
        engine_halted = 1'b0;
        action_count = '{0, 0, 0, 0};
        status_count = '{0, 0, 0, 0};
        foreach (dir_model[i])
            dir_model[i] = '0;
        foreach (leaf_model[i])
            leaf_model[i] = '0;
        dir_choices[0] = 0;
        dir_choices[1] = 1023;
        for (int i = 2; i < 24; i++)
            dir_choices[i] = $urandom_range(0, 1023);

        // Opening table. Rows with a typed response come straight from the
        // address split: empty stores after reset, all-ones and all-zero fields,
        // a miss at the directory and a miss at the leaf.
        opening_rows.push_back(make_row(ACT_XLATE, 32'h0000_0000, '0, '0, '0, '0,
                                        1'b1, ST_ABSENT, 32'h0));
        opening_rows.push_back(make_row(ACT_UNMAP, 32'hFFFF_FFFF, '0, '0, '0, '0,
                                        1'b1, ST_ABSENT, 32'h0));
        opening_rows.push_back(make_row(ACT_MAP, 32'h0000_0000, 32'hFFFF_FFFF, 12'hFFF,
                                        '0, '0, 1'b1, ST_DONE, 32'h0));
        opening_rows.push_back(make_row(ACT_XLATE, 32'h0000_0FFF, '0, '0, '0, '0,
                                        1'b1, ST_DONE, 32'hFFFF_FFFF));
        opening_rows.push_back(make_row(ACT_XLATE, 32'h0000_1000, '0, '0, '0, '0,
                                        1'b1, ST_ABSENT, 32'h0));
        opening_rows.push_back(make_row(ACT_MAP, 32'hFFFF_FFFF, 32'h0, 12'h000, '0, '0,
                                        1'b1, ST_DONE, 32'h0));
        opening_rows.push_back(make_row(ACT_XLATE, 32'hFFFF_F123, '0, '0, '0, '0,
                                        1'b1, ST_DONE, 32'h0000_0123));
        opening_rows.push_back(make_row(ACT_UNMAP, 32'hFFFF_F000, '0, '0, '0, '0,
                                        1'b1, ST_DONE, 32'h0));
        opening_rows.push_back(make_row(ACT_XLATE, 32'hFFFF_F000, '0, '0, '0, '0,
                                        1'b1, ST_ABSENT, 32'h0));
        // Unmap of a leaf that was never written still succeeds when the table exists.
        opening_rows.push_back(make_row(ACT_UNMAP, 32'hFFC0_0000, '0, '0, '0, '0,
                                        1'b1, ST_DONE, 32'h0));
        // The rest go through the model: demand faults with and without the user
        // bit, the largest and smallest frames, overwrites of live leaves, and
        // fields that the action ignores held at values that would otherwise halt.
        opening_rows.push_back(make_row(ACT_FAULT, 32'h1234_5678, '0, '0, 4'h4, 20'hFFFFF,
                                        1'b0, '0, '0));
        opening_rows.push_back(make_row(ACT_XLATE, 32'h1234_5ABC, 32'hFFFF_FFFF, 12'hFFF,
                                        4'hF, 20'h00000, 1'b0, '0, '0));
        opening_rows.push_back(make_row(ACT_FAULT, 32'h1234_5000, '0, '0, 4'h2, 20'h00001,
                                        1'b0, '0, '0));
        opening_rows.push_back(make_row(ACT_XLATE, 32'h1234_5000, '0, '0, '0, '0,
                                        1'b0, '0, '0));
        opening_rows.push_back(make_row(ACT_MAP, 32'h0040_0000, 32'h8000_0000, 12'h004,
                                        '0, '0, 1'b0, '0, '0));
        opening_rows.push_back(make_row(ACT_MAP, 32'h0000_0000, 32'h0000_1000, 12'h000,
                                        4'hF, 20'h00000, 1'b0, '0, '0));
        opening_rows.push_back(make_row(ACT_XLATE, 32'h0000_0000, '0, '0, '0, '0,
                                        1'b0, '0, '0));
        opening_rows.push_back(make_row(ACT_FAULT, 32'h0000_0000, '0, '0, 4'h0, 20'h00001,
                                        1'b0, '0, '0));
        opening_rows.push_back(make_row(ACT_UNMAP, 32'h0040_0000, 32'hFFFF_FFFF, 12'hFFF,
                                        4'h9, 20'h00000, 1'b0, '0, '0));
        opening_rows.push_back(make_row(ACT_XLATE, 32'h0040_0000, '0, '0, '0, '0,
                                        1'b0, '0, '0));

        // Closing table. By now the pool is normally used up, so a map into a
        // fresh directory slot reports no table left. Then a fault with no frame
        // halts the engine, and every request after it, including the other
        // fault errors, reports halted.
        closing_rows.push_back(make_row(ACT_MAP, 32'h5A5A_5000, 32'h1234_5000, 12'h006,
                                        '0, '0, 1'b0, '0, '0));
        closing_rows.push_back(make_row(ACT_FAULT, 32'h0000_0000, '0, '0, 4'h0, 20'h00000,
                                        1'b1, ST_HALTED, 32'h0));
        closing_rows.push_back(make_row(ACT_FAULT, 32'h1234_5000, '0, '0, 4'h1, 20'h00005,
                                        1'b1, ST_HALTED, 32'h0));
        closing_rows.push_back(make_row(ACT_FAULT, 32'h1234_5000, '0, '0, 4'h8, 20'h00005,
                                        1'b1, ST_HALTED, 32'h0));
        closing_rows.push_back(make_row(ACT_MAP, 32'h0000_2000, 32'h0000_3000, 12'h007,
                                        '0, '0, 1'b1, ST_HALTED, 32'h0));
        closing_rows.push_back(make_row(ACT_XLATE, 32'h0000_0000, '0, '0, '0, '0,
                                        1'b1, ST_HALTED, 32'h0));
        closing_rows.push_back(make_row(ACT_UNMAP, 32'h0000_0000, '0, '0, '0, '0,
                                        1'b1, ST_HALTED, 32'h0));

        tx_idle_pct = tx_phase[0];
        rx_idle_pct = rx_phase[0];

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Requests are taken during the directory clear after reset; their
        // responses only appear once the clear is over.
        foreach (opening_rows[i])
            send_request(opening_rows[i]);

        // Three random phases: busy sender with a stalling receiver, the reverse,
        // then both at full rate. Each ends with the sender holding off until the
        // engine has answered everything.
        for (int phase = 0; phase < 3; phase++)
        begin
            tx_idle_pct = tx_phase[phase];
            rx_idle_pct = rx_phase[phase];
            for (int n = 0; n < RANDOM_PER_PHASE; n++)
                send_request(random_request());
            wait_for_drain();
        end

        foreach (closing_rows[i])
            send_request(closing_rows[i]);
        wait_for_drain();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Requests: %0d map, %0d unmap, %0d translate, %0d fault; %0d of %0d tables used.",
                 action_count[ACT_MAP], action_count[ACT_UNMAP], action_count[ACT_XLATE],
                 action_count[ACT_FAULT], tables_taken, TABLE_SLOTS);
        $display("Responses: %0d done, %0d not present, %0d no table left, %0d halted.",
                 status_count[ST_DONE], status_count[ST_ABSENT], status_count[ST_NO_SLOT],
                 status_count[ST_HALTED]);
        if (error_count == 0 && pending_results.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
